// ===== sv/fwbc_pkg.sv =====
package fwbc_pkg;

  localparam int CMD_W       = 2;
  localparam int OFFSET_W    = 31;
  localparam int BLOCK_W     = 19;
  localparam int SLOT_W      = 4;
  localparam int MAX_RESULTS = 16;
  localparam int FCNT_W      = $clog2(MAX_RESULTS);

  typedef enum logic [CMD_W-1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_FLUSH  = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_FLUSH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture request, register tag match / flush set
    logic access;      // resolve hit or miss, emit result
    logic flush_step;  // emit one flush result
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pending_any;
    logic flush_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== sv/fwbc_if.sv =====
interface fwbc_req_if;
  logic                             valid;
  logic                             ready;
  logic [fwbc_pkg::CMD_W-1:0]       command;
  logic [fwbc_pkg::OFFSET_W-1:0]    byte_offset;

  modport source (output valid, output command, output byte_offset, input ready);
  modport sink   (input valid, input command, input byte_offset, output ready);
endinterface

interface fwbc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fwbc_pkg::SLOT_W-1:0]   slot;
  logic                          hit;
  logic                          writeback_valid;
  logic [fwbc_pkg::BLOCK_W-1:0]  writeback_block;
  logic                          fill_valid;
  logic [fwbc_pkg::BLOCK_W-1:0]  fill_block;
  logic                          last;

  modport source (output valid, output slot, output hit, output writeback_valid,
                  output writeback_block, output fill_valid, output fill_block,
                  output last, input ready);
  modport sink   (input valid, input slot, input hit, input writeback_valid,
                  input writeback_block, input fill_valid, input fill_block,
                  input last, output ready);
endinterface

// ===== sv/fwbc_datapath.sv =====
module fwbc_datapath #(
  parameter int ENTRIES     = 16,
  parameter int BLOCK_BYTES = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  fwbc_pkg::ctrl_cmd_t             ctl,
  output fwbc_pkg::dp_status_t            sts,
  input  logic [fwbc_pkg::CMD_W-1:0]      req_command,
  input  logic [fwbc_pkg::OFFSET_W-1:0]   req_byte_offset,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output logic [fwbc_pkg::SLOT_W-1:0]     rsp_slot,
  output logic                            rsp_hit,
  output logic                            rsp_writeback_valid,
  output logic [fwbc_pkg::BLOCK_W-1:0]    rsp_writeback_block,
  output logic                            rsp_fill_valid,
  output logic [fwbc_pkg::BLOCK_W-1:0]    rsp_fill_block,
  output logic                            rsp_last
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SHIFT = $clog2(BLOCK_BYTES);

  logic [fwbc_pkg::BLOCK_W-1:0] tag_store [ENTRIES];
  logic [ENTRIES-1:0]           valid_bits;
  logic [ENTRIES-1:0]           dirty_bits;
  logic [IDX_W-1:0]             replace_ptr;

  fwbc_pkg::cmd_t               cmd_q;
  logic [fwbc_pkg::BLOCK_W-1:0] blk_q;
  // tag match vector for an access, pending dirty set for a flush
  logic [ENTRIES-1:0]           match_q;
  logic [fwbc_pkg::FCNT_W-1:0]  flush_cnt;

  logic [fwbc_pkg::BLOCK_W-1:0] blk_in;
  logic [ENTRIES-1:0]           match_in;
  logic [ENTRIES-1:0]           match_rest;
  logic [IDX_W-1:0]             first_idx;
  logic                         victim_dirty;
  logic                         out_free;

  assign blk_in = fwbc_pkg::BLOCK_W'(req_byte_offset >> SHIFT);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_in[i] = valid_bits[i] && (tag_store[i] == blk_in);
    end
  end

  // lowest set bit of the registered vector
  always_comb begin
    first_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_q[i]) first_idx = IDX_W'(i);
    end
  end

  assign match_rest   = match_q & (match_q - ENTRIES'(1));
  assign victim_dirty = valid_bits[replace_ptr] && dirty_bits[replace_ptr];
  assign out_free     = !rsp_valid || rsp_ready;

  assign sts.pending_any = |match_q;
  assign sts.flush_last  = (match_rest == '0) ||
                           (flush_cnt == fwbc_pkg::FCNT_W'(fwbc_pkg::MAX_RESULTS - 1));
  assign sts.out_free    = out_free;

  // tag store: written only on a miss
  always_ff @(posedge clk) begin
    if (ctl.access && !(|match_q)) begin
      tag_store[replace_ptr] <= blk_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits  <= '0;
      dirty_bits  <= '0;
      replace_ptr <= '0;
    end else if (ctl.access) begin
      if (|match_q) begin
        if (cmd_q == fwbc_pkg::CMD_WRITE) dirty_bits[first_idx] <= 1'b1;
      end else begin
        valid_bits[replace_ptr] <= 1'b1;
        dirty_bits[replace_ptr] <= (cmd_q == fwbc_pkg::CMD_WRITE);
        replace_ptr <= (replace_ptr == IDX_W'(ENTRIES - 1)) ? '0 : replace_ptr + 1'b1;
      end
    end else if (ctl.flush_step && (|match_q)) begin
      dirty_bits[first_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q     <= fwbc_pkg::cmd_t'(req_command);
      blk_q     <= blk_in;
      flush_cnt <= '0;
      if (req_command == fwbc_pkg::CMD_FLUSH) begin
        match_q <= valid_bits & dirty_bits;
      end else begin
        match_q <= match_in;
      end
    end else if (ctl.flush_step && (|match_q)) begin
      match_q[first_idx] <= 1'b0;
      flush_cnt          <= flush_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.access || ctl.flush_step) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.access) begin
      rsp_last <= 1'b1;
      if (|match_q) begin
        rsp_slot            <= fwbc_pkg::SLOT_W'(first_idx);
        rsp_hit             <= 1'b1;
        rsp_writeback_valid <= 1'b0;
        rsp_writeback_block <= '0;
        rsp_fill_valid      <= 1'b0;
        rsp_fill_block      <= '0;
      end else begin
        rsp_slot            <= fwbc_pkg::SLOT_W'(replace_ptr);
        rsp_hit             <= 1'b0;
        rsp_writeback_valid <= victim_dirty;
        rsp_writeback_block <= victim_dirty ? tag_store[replace_ptr] : '0;
        rsp_fill_valid      <= 1'b1;
        rsp_fill_block      <= blk_q;
      end
    end else if (ctl.flush_step) begin
      rsp_hit        <= 1'b0;
      rsp_fill_valid <= 1'b0;
      rsp_fill_block <= '0;
      if (|match_q) begin
        rsp_slot            <= fwbc_pkg::SLOT_W'(first_idx);
        rsp_writeback_valid <= 1'b1;
        rsp_writeback_block <= tag_store[first_idx];
        rsp_last            <= sts.flush_last;
      end else begin
        // nothing dirty: a single empty transaction
        rsp_slot            <= '0;
        rsp_writeback_valid <= 1'b0;
        rsp_writeback_block <= '0;
        rsp_last            <= 1'b1;
      end
    end
  end

endmodule

// ===== sv/fwbc_ctrl.sv =====
module fwbc_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [fwbc_pkg::CMD_W-1:0]  req_command,
  input  fwbc_pkg::dp_status_t        sts,
  output fwbc_pkg::ctrl_cmd_t         ctl
);

  fwbc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fwbc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    req_ready      = 1'b0;
    ctl.load       = 1'b0;
    ctl.access     = 1'b0;
    ctl.flush_step = 1'b0;
    case (state)
      fwbc_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctl.load = 1'b1;
          case (fwbc_pkg::cmd_t'(req_command))
            fwbc_pkg::CMD_READ, fwbc_pkg::CMD_WRITE: state_next = fwbc_pkg::ST_ACCESS;
            fwbc_pkg::CMD_FLUSH:                     state_next = fwbc_pkg::ST_FLUSH;
            default:                                 state_next = fwbc_pkg::ST_IDLE;
          endcase
        end
      end
      fwbc_pkg::ST_ACCESS: begin
        if (sts.out_free) begin
          ctl.access = 1'b1;
          state_next = fwbc_pkg::ST_IDLE;
        end
      end
      fwbc_pkg::ST_FLUSH: begin
        if (sts.out_free) begin
          ctl.flush_step = 1'b1;
          if (!sts.pending_any || sts.flush_last) state_next = fwbc_pkg::ST_IDLE;
        end
      end
      default: state_next = fwbc_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== sv/fifo_write_back_block_cache_tags.sv =====
// Tag and control for a fully associative write-back block cache with FIFO
// replacement. When a read or write request is taken, its block
// number is compared against every valid tag in parallel and the match vector
// is registered. Once the output register is free, the controller resolves hit
// or miss, updates tags, dirty bits and the replacement pointer, and loads the
// output register. A miss reports the victim write-back (if dirty) and the
// fill in the same transaction. A flush emits one transaction per dirty slot,
// lowest slot first, one per cycle while the output register is free (at most
// 16; with none dirty a single empty transaction). A new request is taken as
// soon as the previous one is resolved, even while its result still waits in
// the output register.
module fifo_write_back_block_cache_tags #(
  parameter int ENTRIES     = 16,
  parameter int BLOCK_BYTES = 4096
) (
  input  logic       clk,
  input  logic       rst,
  fwbc_req_if.sink   req,
  fwbc_rsp_if.source rsp
);

  fwbc_pkg::ctrl_cmd_t  ctl;
  fwbc_pkg::dp_status_t sts;

  fwbc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_command (req.command),
    .sts         (sts),
    .ctl         (ctl)
  );

  fwbc_datapath #(
    .ENTRIES     (ENTRIES),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .ctl                 (ctl),
    .sts                 (sts),
    .req_command         (req.command),
    .req_byte_offset     (req.byte_offset),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_slot            (rsp.slot),
    .rsp_hit             (rsp.hit),
    .rsp_writeback_valid (rsp.writeback_valid),
    .rsp_writeback_block (rsp.writeback_block),
    .rsp_fill_valid      (rsp.fill_valid),
    .rsp_fill_block      (rsp.fill_block),
    .rsp_last            (rsp.last)
  );

endmodule
